/* rtl/tpmc_pkg.sv */
`timescale 1ns / 1ps

package tpmc_pkg;

    // field widths
    localparam int FUNC_W  = 3;
    localparam int MASK_W  = 12;
    localparam int KIND_W  = 2;
    localparam int PAD_W   = 4;
    localparam int NOTE_W  = 7;
    localparam int CHAN_W  = 5;
    localparam int VEL_W   = 7;
    localparam int PAGE_W  = 3;
    localparam int SUM_W   = 4;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 7;

    // input function codes
    localparam logic [FUNC_W-1:0] FUNC_SCAN  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_UP    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DOWN  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SHORT = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LONG  = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS   = 2'd2;

    // menu pages
    localparam logic [PAGE_W-1:0] PAGE_SEL  = 3'd0;
    localparam logic [PAGE_W-1:0] PAGE_NOTE = 3'd1;
    localparam logic [PAGE_W-1:0] PAGE_CHAN = 3'd2;
    localparam logic [PAGE_W-1:0] PAGE_VOL  = 3'd3;
    localparam logic [PAGE_W-1:0] PAGE_SUM  = 3'd4;

    // value limits and defaults
    localparam logic [VEL_W-1:0]  VEL_NOTE  = 7'd100;
    localparam logic [NOTE_W-1:0] NOTE_MAX  = 7'd127;
    localparam logic [NOTE_W-1:0] NOTE_BASE = 7'd60;
    localparam logic [CHAN_W-1:0] CHAN_MIN  = 5'd1;
    localparam logic [CHAN_W-1:0] CHAN_MAX  = 5'd16;
    localparam logic [VEL_W-1:0]  VOL_MIN   = 7'd1;
    localparam logic [VEL_W-1:0]  VOL_MAX   = 7'd127;
    localparam logic [VEL_W-1:0]  VOL_INIT  = 7'd100;
    localparam logic [SUM_W-1:0]  SUM_STEP  = 4'd4;
    localparam logic [SUM_W-1:0]  SUM_MAX   = 4'd8;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input transaction
        logic scan_adv;   // retire current scan pad
        logic scan_emit;  // load note event into output register
        logic apply;      // apply user event to menu state
        logic stat_emit;  // load status into output register
        logic rd_sel;     // table read at selected pad (else scan index)
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              chg_none;   // no pad changed on this scan
        logic              bit_set;    // current scan pad changed
        logic              rest_none;  // no changed pad after the current one
        logic              out_free;   // output register can take a result
    } t_dp_sts;

endpackage

/* rtl/tpmc_in_if.sv */
`timescale 1ns / 1ps

interface tpmc_in_if import tpmc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [MASK_W-1:0] touch_mask;

    modport source (output valid, output func, output touch_mask, input ready);
    modport sink   (input valid, input func, input touch_mask, output ready);
endinterface

/* rtl/tpmc_out_if.sv */
`timescale 1ns / 1ps

interface tpmc_out_if import tpmc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [PAD_W-1:0]  pad;
    logic [NOTE_W-1:0] note;
    logic [CHAN_W-1:0] channel;
    logic [VEL_W-1:0]  velocity;
    logic [MASK_W-1:0] led_mask;
    logic              last;
    logic [PAGE_W-1:0] page;
    logic [SUM_W-1:0]  summary_start;
    logic              store_write;
    logic [ADDR_W-1:0] store_address;
    logic [DATA_W-1:0] store_data;

    modport source (
        output valid, output kind, output pad, output note, output channel,
        output velocity, output led_mask, output last, output page,
        output summary_start, output store_write, output store_address,
        output store_data, input ready
    );
    modport sink (
        input valid, input kind, input pad, input note, input channel,
        input velocity, input led_mask, input last, input page,
        input summary_start, input store_write, input store_address,
        input store_data, output ready
    );
endinterface

/* rtl/tpmc_ctrl.sv */
`timescale 1ns / 1ps

module tpmc_ctrl import tpmc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_sts  i_sts,
    output t_ctl_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_APPLY  = 3'd3;
    localparam logic [2:0] S_STAT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.func == FUNC_SCAN) begin
                    n_state = i_sts.chg_none ? S_IDLE : S_SCAN;
                end else if (i_sts.func inside {FUNC_UP, FUNC_DOWN, FUNC_SHORT, FUNC_LONG}) begin
                    n_state = S_APPLY;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                // walk pads one per cycle, wait on a full output register
                if (!i_sts.bit_set) begin
                    o_cmd.scan_adv = 1'b1;
                    if (i_sts.rest_none) begin
                        n_state = S_IDLE;
                    end
                end else if (i_sts.out_free) begin
                    o_cmd.scan_emit = 1'b1;
                    o_cmd.scan_adv  = 1'b1;
                    if (i_sts.rest_none) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_APPLY: begin
                o_cmd.apply  = 1'b1;
                o_cmd.rd_sel = 1'b1;
                n_state      = S_STAT;
            end
            S_STAT: begin
                o_cmd.rd_sel = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.stat_emit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/tpmc_datapath.sv */
`timescale 1ns / 1ps

module tpmc_datapath import tpmc_pkg::*; #(
    parameter int PADS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl_cmd          i_cmd,
    output t_dp_sts           o_sts,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [MASK_W-1:0] i_touch_mask,
    tpmc_out_if.source        o_out
);

    localparam int MB = (PADS < MASK_W) ? PADS : MASK_W;  // scanned pads
    localparam int IW = $clog2(MB);
    localparam int SW = $clog2(PADS);

    // captured transaction and scan state
    logic [FUNC_W-1:0] r_func;
    logic [MB-1:0]     r_prev;
    logic [MB-1:0]     r_pend;
    logic [IW-1:0]     r_idx;

    // menu state
    logic [PAGE_W-1:0] r_page, n_page;
    logic [SW-1:0]     r_sel, n_sel;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic              r_sw, n_sw;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [DATA_W-1:0] r_data, n_data;

    // per-pad tables
    logic [NOTE_W-1:0] r_note [PADS];
    logic [CHAN_W-1:0] r_chan [PADS];
    logic [VEL_W-1:0]  r_vol  [PADS];

    logic              note_we, chan_we, vol_we;
    logic [NOTE_W-1:0] wr_note;
    logic [CHAN_W-1:0] wr_chan;
    logic [VEL_W-1:0]  wr_vol;

    // output register
    logic              r_out_valid;
    logic [KIND_W-1:0] r_kind;
    logic [PAD_W-1:0]  r_pad;
    logic [NOTE_W-1:0] r_o_note;
    logic [CHAN_W-1:0] r_o_chan;
    logic [VEL_W-1:0]  r_o_vel;
    logic [MASK_W-1:0] r_led;
    logic              r_last;
    logic [PAGE_W-1:0] r_o_page;
    logic [SUM_W-1:0]  r_o_sum;
    logic              r_o_sw;
    logic [ADDR_W-1:0] r_o_addr;
    logic [DATA_W-1:0] r_o_data;

    logic [SW-1:0]     rd_a;
    logic [NOTE_W-1:0] rd_note;
    logic [CHAN_W-1:0] rd_chan;
    logic [VEL_W-1:0]  rd_vol;
    logic [MB-1:0]     cur_bit;
    logic              out_free;

    // single table read port
    assign rd_a    = i_cmd.rd_sel ? r_sel : SW'(r_idx);
    assign rd_note = r_note[rd_a];
    assign rd_chan = r_chan[rd_a];
    assign rd_vol  = r_vol[rd_a];

    assign cur_bit  = MB'(1) << r_idx;
    assign out_free = !r_out_valid || o_out.ready;

    assign o_sts.func      = r_func;
    assign o_sts.chg_none  = (r_pend == '0);
    assign o_sts.bit_set   = |(r_pend & cur_bit);
    assign o_sts.rest_none = ((r_pend & ~cur_bit) == '0);
    assign o_sts.out_free  = out_free;

    // menu update for one user event
    always_comb begin
        n_page  = r_page;
        n_sel   = r_sel;
        n_sum   = r_sum;
        n_sw    = 1'b0;
        n_addr  = '0;
        n_data  = '0;
        note_we = 1'b0;
        chan_we = 1'b0;
        vol_we  = 1'b0;
        wr_note = rd_note;
        wr_chan = rd_chan;
        wr_vol  = rd_vol;
        case (r_func)
            FUNC_UP: begin
                case (r_page)
                    PAGE_SEL:  if (r_sel < SW'(PADS - 1)) n_sel = r_sel + 1'b1;
                    PAGE_NOTE: begin
                        note_we = (rd_note < NOTE_MAX);
                        wr_note = rd_note + 1'b1;
                    end
                    PAGE_CHAN: begin
                        chan_we = (rd_chan < CHAN_MAX);
                        wr_chan = rd_chan + 1'b1;
                    end
                    PAGE_VOL: begin
                        vol_we = (rd_vol < VOL_MAX);
                        wr_vol = rd_vol + 1'b1;
                    end
                    default:   if (r_sum < SUM_MAX) n_sum = r_sum + SUM_STEP;
                endcase
            end
            FUNC_DOWN: begin
                case (r_page)
                    PAGE_SEL:  if (r_sel != '0) n_sel = r_sel - 1'b1;
                    PAGE_NOTE: begin
                        note_we = (rd_note != '0);
                        wr_note = rd_note - 1'b1;
                    end
                    PAGE_CHAN: begin
                        chan_we = (rd_chan > CHAN_MIN);
                        wr_chan = rd_chan - 1'b1;
                    end
                    PAGE_VOL: begin
                        vol_we = (rd_vol > VOL_MIN);
                        wr_vol = rd_vol - 1'b1;
                    end
                    default:   if (r_sum != '0) n_sum = r_sum - SUM_STEP;
                endcase
            end
            FUNC_SHORT: begin
                case (r_page)
                    PAGE_SEL:  n_page = PAGE_NOTE;
                    PAGE_NOTE: begin
                        n_page = PAGE_SEL;
                        n_sw   = 1'b1;
                        n_addr = ADDR_W'(r_sel);
                        n_data = rd_note;
                    end
                    PAGE_CHAN: begin
                        n_page = PAGE_NOTE;
                        n_sw   = 1'b1;
                        n_addr = ADDR_W'(PADS) + ADDR_W'(r_sel);
                        n_data = DATA_W'(rd_chan);
                    end
                    PAGE_VOL: begin
                        n_page = PAGE_NOTE;
                        n_sw   = 1'b1;
                        n_addr = ADDR_W'(2 * PADS) + ADDR_W'(r_sel);
                        n_data = rd_vol;
                    end
                    default:   n_page = PAGE_SEL;
                endcase
            end
            FUNC_LONG: begin
                case (r_page)
                    PAGE_SEL: begin
                        n_page = PAGE_SUM;
                        n_sum  = '0;
                    end
                    PAGE_NOTE: n_page = PAGE_CHAN;
                    PAGE_CHAN: n_page = PAGE_VOL;
                    default:   n_page = r_page;
                endcase
            end
            default: begin
                n_page = r_page;
            end
        endcase
    end

    // captured transaction and scan walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_pend <= '0;
            r_func <= FUNC_SCAN;
            r_idx  <= '0;
        end else if (i_cmd.load) begin
            r_func <= i_func;
            r_idx  <= '0;
            if (i_func == FUNC_SCAN) begin
                r_pend <= i_touch_mask[MB-1:0] ^ r_prev;
                r_prev <= i_touch_mask[MB-1:0];
            end else begin
                r_pend <= '0;
            end
        end else if (i_cmd.scan_adv) begin
            r_pend <= r_pend & ~cur_bit;
            r_idx  <= r_idx + 1'b1;
        end
    end

    // menu state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= PAGE_SEL;
            r_sel  <= '0;
            r_sum  <= '0;
            r_sw   <= 1'b0;
        end else if (i_cmd.apply) begin
            r_page <= n_page;
            r_sel  <= n_sel;
            r_sum  <= n_sum;
            r_sw   <= n_sw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_addr <= n_addr;
            r_data <= n_data;
        end
    end

    // tables, written at the selected pad
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PADS; i++) begin
                r_note[i] <= NOTE_BASE + NOTE_W'(i);
                r_chan[i] <= CHAN_MIN;
                r_vol[i]  <= VOL_INIT;
            end
        end else if (i_cmd.apply) begin
            if (note_we) r_note[r_sel] <= wr_note;
            if (chan_we) r_chan[r_sel] <= wr_chan;
            if (vol_we)  r_vol[r_sel]  <= wr_vol;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.scan_emit || i_cmd.stat_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_emit) begin
            r_kind   <= |(r_prev & cur_bit) ? KIND_NOTE_ON : KIND_NOTE_OFF;
            r_pad    <= PAD_W'(r_idx);
            r_o_note <= rd_note;
            r_o_chan <= rd_chan;
            r_o_vel  <= VEL_NOTE;
            r_led    <= MASK_W'(r_prev);
            r_last   <= o_sts.rest_none;
            r_o_page <= r_page;
            r_o_sum  <= r_sum;
            r_o_sw   <= 1'b0;
            r_o_addr <= '0;
            r_o_data <= '0;
        end else if (i_cmd.stat_emit) begin
            r_kind   <= KIND_STATUS;
            r_pad    <= PAD_W'(r_sel);
            r_o_note <= rd_note;
            r_o_chan <= rd_chan;
            r_o_vel  <= rd_vol;
            r_led    <= MASK_W'(r_prev);
            r_last   <= 1'b1;
            r_o_page <= r_page;
            r_o_sum  <= r_sum;
            r_o_sw   <= r_sw;
            r_o_addr <= r_sw ? r_addr : '0;
            r_o_data <= r_sw ? r_data : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.pad           = r_pad;
    assign o_out.note          = r_o_note;
    assign o_out.channel       = r_o_chan;
    assign o_out.velocity      = r_o_vel;
    assign o_out.led_mask      = r_led;
    assign o_out.last          = r_last;
    assign o_out.page          = r_o_page;
    assign o_out.summary_start = r_o_sum;
    assign o_out.store_write   = r_o_sw;
    assign o_out.store_address = r_o_addr;
    assign o_out.store_data    = r_o_data;

endmodule

/* rtl/touch_pad_midi_note_controller.sv */
`timescale 1ns / 1ps

// Touch pad MIDI note controller. Works on one input transaction at a time:
// a user event (encoder up/down, short/long press) gives one menu status
// result through capture, decode, apply and emit; a touch scan is captured
// and decoded, then the controller walks the pads one per cycle, stalling on
// a full output register, from pad 0 up to the highest pad that changed,
// through a single table read port and emits note-on/note-off in pad order.
// A scan with no change, or an unused function code, gives no result. Every
// result passes through one output register, so a stalled sink stalls the
// block; the next transaction is taken as soon as the last result sits in
// that register. Per-pad note, channel and volume tables come out of reset
// at note 60 plus pad, channel 1 and volume 100.

module touch_pad_midi_note_controller import tpmc_pkg::*; #(
    parameter int PADS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpmc_in_if.sink    i_in,
    tpmc_out_if.source o_out
);

    t_ctl_cmd w_cmd;
    t_dp_sts  w_sts;
    logic     w_in_ready;

    assign i_in.ready = w_in_ready;

    tpmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tpmc_datapath #(
        .PADS (PADS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_func       (i_in.func),
        .i_touch_mask (i_in.touch_mask),
        .o_out        (o_out)
    );

endmodule

/* rtl/tpmc_checker.sv */
`timescale 1ns / 1ps

module tpmc_checker import tpmc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [KIND_W-1:0] i_out_kind,
    input logic [PAD_W-1:0]  i_out_pad,
    input logic [VEL_W-1:0]  i_out_velocity,
    input logic              i_out_last,
    input logic              i_out_store_write
);

    // one transaction at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while previous transaction in work");

    // a status result is always the only result of its transaction
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind == KIND_STATUS) |-> i_out_last)
        else $error("status result without last");

    // note events carry fixed velocity and never a store write
    a_note_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind != KIND_STATUS)
            |-> (i_out_velocity == VEL_NOTE && !i_out_store_write))
        else $error("note event with bad velocity or store write");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
            |=> (i_out_valid && $stable(i_out_kind) && $stable(i_out_pad)))
        else $error("stalled result changed");

endmodule

bind touch_pad_midi_note_controller tpmc_checker u_tpmc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_kind        (o_out.kind),
    .i_out_pad         (o_out.pad),
    .i_out_velocity    (o_out.velocity),
    .i_out_last        (o_out.last),
    .i_out_store_write (o_out.store_write)
);

/* bench/touch_pad_midi_note_controller_tb.sv */
`timescale 1ns / 1ps

module touch_pad_midi_note_controller_tb;
    import tpmc_pkg::*;

    localparam int PADS             = 12;
    localparam int RANDOM_ITEMS     = 320;
    localparam int LONG_HOLD_CYCLES = 250;
    localparam int SETTLE_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT   = 2000;

    // function codes the block ignores
    localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [PAD_W-1:0]  pad;
        logic [NOTE_W-1:0] note;
        logic [CHAN_W-1:0] channel;
        logic [VEL_W-1:0]  velocity;
        logic [MASK_W-1:0] led_mask;
        logic              last;
        logic [PAGE_W-1:0] page;
        logic [SUM_W-1:0]  summary_start;
        logic              store_write;
        logic [ADDR_W-1:0] store_address;
        logic [DATA_W-1:0] store_data;
    } midi_result_t;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [MASK_W-1:0] mask;
        bit                typed;
        midi_result_t      res;
    } stim_row_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tpmc_in_if  in_if ();
    tpmc_out_if out_if ();

    touch_pad_midi_note_controller #(.PADS(PADS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the controller state
    logic [MASK_W-1:0] model_touch;
    logic [PAGE_W-1:0] model_page;
    logic [PAD_W-1:0]  model_sel;
    logic [SUM_W-1:0]  model_sum_first;
    logic [NOTE_W-1:0] note_of [PADS];
    logic [CHAN_W-1:0] chan_of [PADS];
    logic [VEL_W-1:0]  vol_of  [PADS];

    midi_result_t step_results[$];
    midi_result_t pending_results[$];
    midi_result_t no_result = '{default: '0};

    int answered_items = 0;
    int fail_count     = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit hold_request   = 1'b0;

    function automatic midi_result_t make_result(
        input logic [KIND_W-1:0] kind,
        input logic [PAD_W-1:0]  pad,
        input logic [NOTE_W-1:0] note,
        input logic [CHAN_W-1:0] channel,
        input logic [VEL_W-1:0]  velocity,
        input logic [MASK_W-1:0] led_mask,
        input logic              last,
        input logic [PAGE_W-1:0] page,
        input logic [SUM_W-1:0]  summary_start,
        input logic              store_write,
        input logic [ADDR_W-1:0] store_address,
        input logic [DATA_W-1:0] store_data
    );
        midi_result_t r;
        r.kind          = kind;
        r.pad           = pad;
        r.note          = note;
        r.channel       = channel;
        r.velocity      = velocity;
        r.led_mask      = led_mask;
        r.last          = last;
        r.page          = page;
        r.summary_start = summary_start;
        r.store_write   = store_write;
        r.store_address = store_address;
        r.store_data    = store_data;
        return r;
    endfunction

    // Advance the shadow state by one transaction; results land in step_results.
    function automatic void predict_midi_results(input logic [FUNC_W-1:0] f,
                                                 input logic [MASK_W-1:0] m);
        logic [MASK_W-1:0] changed;
        int                final_pad;
        logic [PAD_W-1:0]  sel;
        logic              wr;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        step_results.delete();
        wr      = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (f == FUNC_SCAN) begin
            changed     = m ^ model_touch;
            model_touch = m;
            final_pad   = -1;
            for (int i = 0; i < PADS; i++)
                if (changed[i]) final_pad = i;
            // note events walk the changed pads in ascending order
            for (int i = 0; i < PADS; i++) begin
                if (changed[i])
                    step_results.push_back(make_result(
                        m[i] ? KIND_NOTE_ON : KIND_NOTE_OFF, PAD_W'(i), note_of[i],
                        chan_of[i], VEL_NOTE, model_touch, i == final_pad, model_page,
                        model_sum_first, 1'b0, '0, '0));
            end
        end else if (f <= FUNC_LONG) begin
            sel = model_sel;
            case (f)
                FUNC_UP: begin
                    case (model_page)
                        PAGE_SEL:  if (sel < PADS - 1) model_sel = sel + 1'b1;
                        PAGE_NOTE: if (note_of[sel] < NOTE_MAX) note_of[sel]++;
                        PAGE_CHAN: if (chan_of[sel] < CHAN_MAX) chan_of[sel]++;
                        PAGE_VOL:  if (vol_of[sel] < VOL_MAX) vol_of[sel]++;
                        default:   if (model_sum_first < SUM_MAX)
                                       model_sum_first += SUM_STEP;
                    endcase
                end
                FUNC_DOWN: begin
                    case (model_page)
                        PAGE_SEL:  if (sel > 0) model_sel = sel - 1'b1;
                        PAGE_NOTE: if (note_of[sel] > 0) note_of[sel]--;
                        PAGE_CHAN: if (chan_of[sel] > CHAN_MIN) chan_of[sel]--;
                        PAGE_VOL:  if (vol_of[sel] > VOL_MIN) vol_of[sel]--;
                        default:   if (model_sum_first > 0)
                                       model_sum_first -= SUM_STEP;
                    endcase
                end
                FUNC_SHORT: begin
                    // leaving an edit page reports the edited value
                    case (model_page)
                        PAGE_SEL: model_page = PAGE_NOTE;
                        PAGE_NOTE: begin
                            model_page = PAGE_SEL;
                            wr         = 1'b1;
                            wr_addr    = ADDR_W'(sel);
                            wr_data    = note_of[sel];
                        end
                        PAGE_CHAN: begin
                            model_page = PAGE_NOTE;
                            wr         = 1'b1;
                            wr_addr    = ADDR_W'(PADS) + ADDR_W'(sel);
                            wr_data    = DATA_W'(chan_of[sel]);
                        end
                        PAGE_VOL: begin
                            model_page = PAGE_NOTE;
                            wr         = 1'b1;
                            wr_addr    = ADDR_W'(2 * PADS) + ADDR_W'(sel);
                            wr_data    = vol_of[sel];
                        end
                        default: model_page = PAGE_SEL;
                    endcase
                end
                default: begin
                    if (model_page == PAGE_SEL) begin
                        model_sum_first = '0;
                        model_page      = PAGE_SUM;
                    end else if (model_page == PAGE_NOTE) begin
                        model_page = PAGE_CHAN;
                    end else if (model_page == PAGE_CHAN) begin
                        model_page = PAGE_VOL;
                    end
                end
            endcase
            step_results.push_back(make_result(
                KIND_STATUS, model_sel, note_of[model_sel], chan_of[model_sel],
                vol_of[model_sel], model_touch, 1'b1, model_page, model_sum_first,
                wr, wr_addr, wr_data));
        end
    endfunction

    // next press on the way from one menu page to another
    function automatic logic [FUNC_W-1:0] nav_step(input logic [PAGE_W-1:0] from_pg,
                                                   input logic [PAGE_W-1:0] to_pg);
        case (to_pg)
            PAGE_CHAN: return (from_pg == PAGE_NOTE) ? FUNC_LONG : FUNC_SHORT;
            PAGE_VOL:  return (from_pg == PAGE_NOTE || from_pg == PAGE_CHAN) ?
                              FUNC_LONG : FUNC_SHORT;
            PAGE_SUM:  return (from_pg == PAGE_SEL) ? FUNC_LONG : FUNC_SHORT;
            default:   return FUNC_SHORT;
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Offer one transaction, wait for it to be taken, then queue its results.
    task automatic issue_event(input logic [FUNC_W-1:0] f, input logic [MASK_W-1:0] m,
                               input bit typed, input midi_result_t typed_res);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.func       <= f;
        in_if.touch_mask <= m;
        do @(posedge i_clk); while (!in_if.ready);
        predict_midi_results(f, m);
        if (step_results.size() != 0) answered_items++;
        if (typed)
            pending_results.push_back(typed_res);
        else
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
    endtask

    // sender pause: everything predicted has come out and the block is idle
    task automatic wait_for_results_drained();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result side: check each accepted result, then pick next ready
    initial begin
        midi_result_t want;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: kind %0d pad %0d note %0d", $time,
                             out_if.kind, out_if.pad, out_if.note);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(out_if.kind));
                    check_field("pad", 32'(want.pad), 32'(out_if.pad));
                    check_field("note", 32'(want.note), 32'(out_if.note));
                    check_field("channel", 32'(want.channel), 32'(out_if.channel));
                    check_field("velocity", 32'(want.velocity), 32'(out_if.velocity));
                    check_field("led_mask", 32'(want.led_mask), 32'(out_if.led_mask));
                    check_field("last", 32'(want.last), 32'(out_if.last));
                    check_field("page", 32'(want.page), 32'(out_if.page));
                    check_field("summary_start", 32'(want.summary_start),
                                32'(out_if.summary_start));
                    check_field("store_write", 32'(want.store_write),
                                32'(out_if.store_write));
                    check_field("store_address", 32'(want.store_address),
                                32'(out_if.store_address));
                    check_field("store_data", 32'(want.store_data),
                                32'(out_if.store_data));
                end
            end
            // long back-pressure so the block fills and stalls its input
            if (hold_request) begin
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            out_if.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
        end
    end

    // watchdog on transaction progress
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** touch_pad_midi_note_controller: FAILED **");
        $finish;
    end

    // stimulus
    initial begin
        stim_row_t         directed_rows[$];
        logic [FUNC_W-1:0] f;
        logic [MASK_W-1:0] m;
        logic [PAGE_W-1:0] target_page;
        int                phase_goal;
        int                episode;
        int                run_len;
        int                pick;
        bit                run_up;

        in_if.valid      = 1'b0;
        in_if.func       = FUNC_SCAN;
        in_if.touch_mask = '0;

        model_touch     = '0;
        model_page      = PAGE_SEL;
        model_sel       = '0;
        model_sum_first = '0;
        for (int i = 0; i < PADS; i++) begin
            note_of[i] = NOTE_BASE + NOTE_W'(i);
            chan_of[i] = CHAN_MIN;
            vol_of[i]  = VOL_INIT;
        end

        // directed walk from reset: no-change scans, ignored codes, single and
        // all-pad note events, every menu page, saturation and store writes
        directed_rows.push_back('{FUNC_SCAN, 12'h000, 1'b0, no_result});
        directed_rows.push_back('{FUNC_SPARE_5, 12'hABC, 1'b0, no_result});
        directed_rows.push_back('{FUNC_SCAN, 12'h001, 1'b1, make_result(KIND_NOTE_ON,
            '0, NOTE_BASE, CHAN_MIN, VEL_NOTE, 12'h001, 1'b1, PAGE_SEL, '0, 1'b0, '0, '0)});
        directed_rows.push_back('{FUNC_SCAN, 12'h000, 1'b1, make_result(KIND_NOTE_OFF,
            '0, NOTE_BASE, CHAN_MIN, VEL_NOTE, 12'h000, 1'b1, PAGE_SEL, '0, 1'b0, '0, '0)});
        directed_rows.push_back('{FUNC_SCAN, 12'h800, 1'b1, make_result(KIND_NOTE_ON,
            PAD_W'(PADS - 1), NOTE_BASE + NOTE_W'(PADS - 1), CHAN_MIN, VEL_NOTE, 12'h800,
            1'b1, PAGE_SEL, '0, 1'b0, '0, '0)});
        directed_rows.push_back('{FUNC_SCAN, 12'hFFF, 1'b0, no_result});
        directed_rows.push_back('{FUNC_SCAN, 12'h000, 1'b0, no_result});
        directed_rows.push_back('{FUNC_DOWN, 12'h000, 1'b1, make_result(KIND_STATUS,
            '0, NOTE_BASE, CHAN_MIN, VOL_INIT, '0, 1'b1, PAGE_SEL, '0, 1'b0, '0, '0)});
        directed_rows.push_back('{FUNC_SHORT, 12'h000, 1'b1, make_result(KIND_STATUS,
            '0, NOTE_BASE, CHAN_MIN, VOL_INIT, '0, 1'b1, PAGE_NOTE, '0, 1'b0, '0, '0)});
        directed_rows.push_back('{FUNC_UP, 12'h000, 1'b1, make_result(KIND_STATUS,
            '0, NOTE_BASE + 7'd1, CHAN_MIN, VOL_INIT, '0, 1'b1, PAGE_NOTE, '0, 1'b0,
            '0, '0)});
        directed_rows.push_back('{FUNC_LONG, 12'h000, 1'b0, no_result});
        directed_rows.push_back('{FUNC_DOWN, 12'h000, 1'b1, make_result(KIND_STATUS,
            '0, NOTE_BASE + 7'd1, CHAN_MIN, VOL_INIT, '0, 1'b1, PAGE_CHAN, '0, 1'b0,
            '0, '0)});
        directed_rows.push_back('{FUNC_UP, 12'h000, 1'b0, no_result});
        directed_rows.push_back('{FUNC_LONG, 12'h000, 1'b0, no_result});
        directed_rows.push_back('{FUNC_UP, 12'h000, 1'b0, no_result});
        directed_rows.push_back('{FUNC_SHORT, 12'h000, 1'b1, make_result(KIND_STATUS,
            '0, NOTE_BASE + 7'd1, CHAN_MIN + 5'd1, VOL_INIT + 7'd1, '0, 1'b1, PAGE_NOTE,
            '0, 1'b1, ADDR_W'(2 * PADS), VOL_INIT + 7'd1)});
        directed_rows.push_back('{FUNC_LONG, 12'h000, 1'b0, no_result});
        directed_rows.push_back('{FUNC_SHORT, 12'h000, 1'b1, make_result(KIND_STATUS,
            '0, NOTE_BASE + 7'd1, CHAN_MIN + 5'd1, VOL_INIT + 7'd1, '0, 1'b1, PAGE_NOTE,
            '0, 1'b1, ADDR_W'(PADS), DATA_W'(CHAN_MIN + 5'd1))});
        directed_rows.push_back('{FUNC_SHORT, 12'h000, 1'b1, make_result(KIND_STATUS,
            '0, NOTE_BASE + 7'd1, CHAN_MIN + 5'd1, VOL_INIT + 7'd1, '0, 1'b1, PAGE_SEL,
            '0, 1'b1, '0, NOTE_BASE + 7'd1)});
        directed_rows.push_back('{FUNC_LONG, 12'h000, 1'b0, no_result});
        directed_rows.push_back('{FUNC_DOWN, 12'h000, 1'b1, make_result(KIND_STATUS,
            '0, NOTE_BASE + 7'd1, CHAN_MIN + 5'd1, VOL_INIT + 7'd1, '0, 1'b1, PAGE_SUM,
            '0, 1'b0, '0, '0)});
        directed_rows.push_back('{FUNC_UP, 12'h000, 1'b0, no_result});
        directed_rows.push_back('{FUNC_UP, 12'h000, 1'b0, no_result});
        directed_rows.push_back('{FUNC_UP, 12'h000, 1'b1, make_result(KIND_STATUS,
            '0, NOTE_BASE + 7'd1, CHAN_MIN + 5'd1, VOL_INIT + 7'd1, '0, 1'b1, PAGE_SUM,
            SUM_MAX, 1'b0, '0, '0)});
        directed_rows.push_back('{FUNC_LONG, 12'h000, 1'b0, no_result});
        directed_rows.push_back('{FUNC_SHORT, 12'h000, 1'b0, no_result});
        directed_rows.push_back('{FUNC_SPARE_7, 12'hFFF, 1'b0, no_result});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            issue_event(directed_rows[i].func, directed_rows[i].mask,
                        directed_rows[i].typed, directed_rows[i].res);
        wait_for_results_drained();

        // random phases with different idle and stall mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                    hold_request   = 1'b1;
                end
                1: begin
                    src_idle_pct   = 55;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 55;
                end
                default: begin
                    src_idle_pct   = 26;
                    sink_stall_pct = 26;
                end
            endcase
            phase_goal = answered_items + RANDOM_ITEMS / 4;
            while (answered_items < phase_goal) begin
                episode = $urandom_range(99, 0);
                if (episode < 35) begin
                    // burst of scans: wide changes, one or two pads, or no change
                    repeat ($urandom_range(8, 1)) begin
                        case ($urandom_range(3, 0))
                            0: m = MASK_W'($urandom);
                            1: m = model_touch ^ (MASK_W'(1) << $urandom_range(PADS - 1, 0));
                            2: m = model_touch ^ (MASK_W'(1) << $urandom_range(PADS - 1, 0))
                                   ^ (MASK_W'(1) << $urandom_range(PADS - 1, 0));
                            default: m = model_touch;
                        endcase
                        issue_event(FUNC_SCAN, m, 1'b0, no_result);
                    end
                end else if (episode < 88) begin
                    // walk to a page, then a run of encoder steps in mostly one direction
                    target_page = PAGE_W'($urandom_range(PAGE_SUM, PAGE_SEL));
                    while (model_page != target_page)
                        issue_event(nav_step(model_page, target_page), MASK_W'($urandom),
                                    1'b0, no_result);
                    run_len = ($urandom_range(4, 0) == 0) ? $urandom_range(80, 30)
                                                          : $urandom_range(12, 1);
                    run_up  = ($urandom_range(1, 0) == 1);
                    repeat (run_len) begin
                        pick = $urandom_range(99, 0);
                        m    = MASK_W'($urandom);
                        if (pick < 85) begin
                            f = run_up ? FUNC_UP : FUNC_DOWN;
                        end else if (pick < 93) begin
                            f = run_up ? FUNC_DOWN : FUNC_UP;
                        end else if (pick < 97) begin
                            f = FUNC_SCAN;
                            m = model_touch ^ (MASK_W'(1) << $urandom_range(PADS - 1, 0));
                        end else begin
                            f = FUNC_W'($urandom_range(FUNC_SPARE_7, FUNC_SPARE_5));
                        end
                        issue_event(f, m, 1'b0, no_result);
                    end
                end else begin
                    // noise: any code, any mask
                    repeat ($urandom_range(4, 1))
                        issue_event(FUNC_W'($urandom_range(FUNC_SPARE_7, FUNC_SCAN)),
                                    MASK_W'($urandom), 1'b0, no_result);
                end
            end
            wait_for_results_drained();
        end

        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("** touch_pad_midi_note_controller: PASSED **");
        else
            $display("** touch_pad_midi_note_controller: FAILED **");
        $finish;
    end

endmodule
